[sv/bsrt_pkg.sv]
// ----------------------------------------------------------------------------
// bsrt_pkg
// Shared constants, codes and types of the bound slot run tracker.
// ----------------------------------------------------------------------------
package bsrt_pkg;

  localparam int MAX_SLOTS   = 128;
  localparam int MAX_RESULTS = 64;

  localparam int IDX_W    = $clog2(MAX_SLOTS);
  localparam int CNT_W    = $clog2(MAX_SLOTS + 1);
  localparam int NRES_W   = $clog2(MAX_RESULTS + 1);

  localparam int ACTION_W = 2;
  localparam int SLOT_W   = 8;
  localparam int HANDLE_W = 32;
  localparam int LEN_W    = 8;
  localparam int BASE_W   = 7;
  localparam int SCNT_W   = 8;
  localparam int CFG_W    = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CMP_W    = SLOT_W + 1;

  localparam logic [ACTION_W-1:0] ACT_SET  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_CAS  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_LIST = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_SLOT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 1'd1;

  typedef struct packed {
    logic                applied;
    logic [SLOT_W-1:0]   first_slot;
    logic [LEN_W-1:0]    run_length;
    logic                last;
  } res_t;

  typedef struct packed {
    logic                we;
    logic                re;
    logic [IDX_W-1:0]    addr;
    logic [HANDLE_W-1:0] wdata;
  } ram_req_t;

endpackage

[sv/bsrt_if.sv]
// ----------------------------------------------------------------------------
// bsrt_if
// Valid/ready channels for the item input and the result output.
// ----------------------------------------------------------------------------
interface bsrt_in_if import bsrt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [SLOT_W-1:0]   slot_number;
  logic [HANDLE_W-1:0] new_handle;
  logic [HANDLE_W-1:0] expected_handle;

  modport source (output valid, output action, output slot_number,
                  output new_handle, output expected_handle, input ready);
  modport sink   (input valid, input action, input slot_number,
                  input new_handle, input expected_handle, output ready);
endinterface

interface bsrt_out_if import bsrt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                applied;
  logic [SLOT_W-1:0]   first_slot;
  logic [LEN_W-1:0]    run_length;
  logic                last;

  modport source (output valid, output applied, output first_slot,
                  output run_length, output last, input ready);
  modport sink   (input valid, input applied, input first_slot,
                  input run_length, input last, output ready);
endinterface

[sv/bsrt_handle_ram.sv]
// ----------------------------------------------------------------------------
// bsrt_handle_ram
// Single-port handle store with registered read data.
// ----------------------------------------------------------------------------
module bsrt_handle_ram import bsrt_pkg::*; (
  input  logic                clk_i,
  input  ram_req_t            req_i,
  output logic [HANDLE_W-1:0] rdata_o
);

  logic [HANDLE_W-1:0] mem [MAX_SLOTS];
  logic [HANDLE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/bsrt_seq.sv]
// ----------------------------------------------------------------------------
// bsrt_seq
// Sequencer: window registers, occupancy map, set/compare-and-set update and
// bit-serial run scan around one shared window compare.
// ----------------------------------------------------------------------------
module bsrt_seq import bsrt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  bsrt_in_if.sink              in_i,
  output ram_req_t             ram_req_o,
  input  logic [HANDLE_W-1:0]  ram_rdata_i,
  output logic                 res_valid_o,
  output res_t                 res_o,
  input  logic                 res_ready_i
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHECK, ST_CMP, ST_RESP, ST_SCAN, ST_FINAL
  } state_e;

  state_e               state_q, state_d;
  logic [BASE_W-1:0]    base_q, base_d;
  logic [SCNT_W-1:0]    scnt_q, scnt_d;
  logic [MAX_SLOTS-1:0] occ_q, occ_d;
  logic [ACTION_W-1:0]  act_q, act_d;
  logic [SLOT_W-1:0]    slot_q, slot_d;
  logic [HANDLE_W-1:0]  nh_q, nh_d;
  logic [HANDLE_W-1:0]  eh_q, eh_d;
  logic                 applied_q, applied_d;
  logic [CNT_W-1:0]     idx_q, idx_d;
  logic                 in_run_q, in_run_d;
  logic [SLOT_W-1:0]    run_first_q, run_first_d;
  logic [LEN_W-1:0]     run_len_q, run_len_d;
  logic                 pend_valid_q, pend_valid_d;
  logic [SLOT_W-1:0]    pend_first_q, pend_first_d;
  logic [LEN_W-1:0]     pend_len_q, pend_len_d;
  logic [NRES_W-1:0]    n_q, n_d;

  logic [CNT_W-1:0]     cnt;
  logic [CMP_W-1:0]     diff;
  logic [CMP_W-1:0]     cmp_a;
  logic                 lt;
  logic                 bit_occ;
  logic                 close;
  logic                 emit;
  logic                 go;
  logic                 last_flag;
  logic [HANDLE_W-1:0]  cur;
  logic                 hit;

  assign cnt = ({1'b0, scnt_q} >= CMP_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS)
                                                     : CNT_W'(scnt_q);
  assign diff  = {1'b0, slot_q} - CMP_W'(base_q);
  assign cmp_a = (state_q == ST_SCAN) ? CMP_W'(idx_q) : diff;
  assign lt    = cmp_a < CMP_W'(cnt);

  assign bit_occ   = occ_q[idx_q[IDX_W-1:0]];
  assign close     = in_run_q && (!lt || !bit_occ);
  assign emit      = close && pend_valid_q;
  assign last_flag = (n_q == NRES_W'(MAX_RESULTS - 1));
  assign cur       = occ_q[idx_q[IDX_W-1:0]] ? ram_rdata_i : '0;
  assign hit       = (act_q == ACT_SET) || (cur == eh_q);

  assign in_i.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d      = state_q;
    base_d       = base_q;
    scnt_d       = scnt_q;
    occ_d        = occ_q;
    act_d        = act_q;
    slot_d       = slot_q;
    nh_d         = nh_q;
    eh_d         = eh_q;
    applied_d    = applied_q;
    idx_d        = idx_q;
    in_run_d     = in_run_q;
    run_first_d  = run_first_q;
    run_len_d    = run_len_q;
    pend_valid_d = pend_valid_q;
    pend_first_d = pend_first_q;
    pend_len_d   = pend_len_q;
    n_d          = n_q;
    ram_req_o    = '0;
    res_valid_o  = 1'b0;
    res_o        = '{applied: 1'b0, first_slot: '0, run_length: '0, last: 1'b1};
    go           = 1'b1;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BASE_SLOT:  base_d = cfg_wdata_i[BASE_W-1:0];
        CFG_SLOT_COUNT: scnt_d = cfg_wdata_i[SCNT_W-1:0];
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        act_d  = in_i.action;
        slot_d = in_i.slot_number;
        nh_d   = in_i.new_handle;
        eh_d   = in_i.expected_handle;
        if (in_i.valid) begin
          case (in_i.action)
            ACT_SET, ACT_CAS: state_d = ST_CHECK;
            ACT_LIST: begin
              idx_d        = '0;
              in_run_d     = 1'b0;
              pend_valid_d = 1'b0;
              n_d          = '0;
              state_d      = ST_SCAN;
            end
            default: begin
              applied_d = 1'b0;
              state_d   = ST_RESP;
            end
          endcase
        end
      end

      ST_CHECK: begin
        if (lt) begin
          idx_d          = CNT_W'(diff);
          ram_req_o.re   = 1'b1;
          ram_req_o.addr = diff[IDX_W-1:0];
          state_d        = ST_CMP;
        end else begin
          applied_d = 1'b0;
          state_d   = ST_RESP;
        end
      end

      ST_CMP: begin
        applied_d = hit;
        if (hit) begin
          ram_req_o.we                = 1'b1;
          ram_req_o.addr              = idx_q[IDX_W-1:0];
          ram_req_o.wdata             = nh_q;
          occ_d[idx_q[IDX_W-1:0]]     = |nh_q;
        end
        state_d = ST_RESP;
      end

      ST_RESP: begin
        res_valid_o   = 1'b1;
        res_o.applied = applied_q;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      ST_SCAN: begin
        if (emit) begin
          res_valid_o      = 1'b1;
          res_o.first_slot = pend_first_q;
          res_o.run_length = pend_len_q;
          res_o.last       = last_flag;
          go               = res_ready_i;
        end
        if (go) begin
          if (emit && last_flag) begin
            state_d = ST_IDLE;
          end else begin
            if (emit) begin
              n_d = n_q + 1'b1;
            end
            if (close) begin
              pend_valid_d = 1'b1;
              pend_first_d = run_first_q;
              pend_len_d   = run_len_q;
              in_run_d     = 1'b0;
            end
            if (lt) begin
              if (bit_occ) begin
                if (in_run_q) begin
                  run_len_d = run_len_q + 1'b1;
                end else begin
                  in_run_d    = 1'b1;
                  run_first_d = SLOT_W'(base_q) + SLOT_W'(idx_q);
                  run_len_d   = LEN_W'(1);
                end
              end
              idx_d = idx_q + 1'b1;
            end else if (!in_run_q) begin
              state_d = ST_FINAL;
            end
          end
        end
      end

      ST_FINAL: begin
        res_valid_o = 1'b1;
        if (pend_valid_q) begin
          res_o.first_slot = pend_first_q;
          res_o.run_length = pend_len_q;
        end
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      base_q       <= '0;
      scnt_q       <= '0;
      occ_q        <= '0;
      applied_q    <= 1'b0;
      idx_q        <= '0;
      in_run_q     <= 1'b0;
      pend_valid_q <= 1'b0;
      n_q          <= '0;
    end else begin
      state_q      <= state_d;
      base_q       <= base_d;
      scnt_q       <= scnt_d;
      occ_q        <= occ_d;
      applied_q    <= applied_d;
      idx_q        <= idx_d;
      in_run_q     <= in_run_d;
      pend_valid_q <= pend_valid_d;
      n_q          <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q        <= act_d;
    slot_q       <= slot_d;
    nh_q         <= nh_d;
    eh_q         <= eh_d;
    run_first_q  <= run_first_d;
    run_len_q    <= run_len_d;
    pend_first_q <= pend_first_d;
    pend_len_q   <= pend_len_d;
  end

`ifndef SYNTH
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> CMP_W'(idx_q) <= CMP_W'(cnt))
    else $error("scan index past window");

  a_emit_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && state_q == ST_SCAN) |-> (pend_valid_q && n_q < NRES_W'(MAX_RESULTS)))
    else $error("run emitted without pending run or past result cap");

  a_leave_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> state_q != ST_IDLE)
    else $error("accepted transaction not processed");

  a_occ_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_req_o.we |=> occ_q[$past(ram_req_o.addr)] == ($past(ram_req_o.wdata) != '0))
    else $error("occupancy map out of step with handle store");
`endif

endmodule

[sv/bsrt_out_reg.sv]
// ----------------------------------------------------------------------------
// bsrt_out_reg
// One-entry output register between the sequencer and the result channel.
// ----------------------------------------------------------------------------
module bsrt_out_reg import bsrt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      res_valid_i,
  input  res_t      res_i,
  output logic      res_ready_o,
  bsrt_out_if.source out_o
);

  logic valid_q, valid_d;
  res_t data_q;
  logic load;

  assign res_ready_o = !valid_q || out_o.ready;
  assign load        = res_valid_i && res_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= res_i;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.applied    = data_q.applied;
  assign out_o.first_slot = data_q.first_slot;
  assign out_o.run_length = data_q.run_length;
  assign out_o.last       = data_q.last;

endmodule

[sv/bound_slot_run_tracker_top.sv]
// ----------------------------------------------------------------------------
// bound_slot_run_tracker_top
// Slot handle store with set, compare-and-set and occupied-run listing.
//
//   channel  dir  fields
//   in_i     in   action, slot_number, new_handle, expected_handle
//   out_o    out  applied, first_slot, run_length, last
//   cfg      in   cfg_we_i, cfg_idx_i, cfg_wdata_i (base_slot, slot_count)
//
// Set and compare-and-set pass from accept through window check and handle
// read, compare and update, result and back to idle. A slot outside the
// window skips the handle read and the compare; an unknown action goes
// straight to the result. A list scans the usable slots of the window and
// then gives its final result; the sequencer walks the occupancy map one
// slot a cycle unless a result waits on the channel. Results leave through
// one output register. A stalled result channel holds the scan. Reset clears
// the occupancy map at once, so no clearing pass. One transaction is in work
// at a time; in_i.ready is high only when idle.
// ----------------------------------------------------------------------------
module bound_slot_run_tracker_top import bsrt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  bsrt_in_if.sink              in_i,
  bsrt_out_if.source           out_o
);

  ram_req_t            ram_req;
  logic [HANDLE_W-1:0] ram_rdata;
  logic                res_valid;
  logic                res_ready;
  res_t                res;

  bsrt_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  bsrt_handle_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  bsrt_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .res_ready_o (res_ready),
    .out_o       (out_o)
  );

endmodule

[test/slot_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_result_checker
// Watches the item, result and register channels of the bound slot run
// tracker. Keeps its own copy of the slot handles, the occupancy and the
// window, and predicts every result of an accepted item. Checks each accepted
// result field by field against the oldest prediction and counts failures.
// ----------------------------------------------------------------------------
module slot_result_checker import bsrt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  bsrt_in_if                   item_mon,
  bsrt_out_if                  result_mon,
  output int unsigned          fail_count_o,
  output int unsigned          due_count_o
);

  logic [HANDLE_W-1:0]  slot_handle [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] occupied;
  logic [BASE_W-1:0]    win_base;
  logic [SCNT_W-1:0]    win_count;
  res_t                 due_results [$];

  function automatic int unsigned usable_slots();
    return (win_count < MAX_SLOTS) ? int'(win_count) : MAX_SLOTS;
  endfunction

  task automatic report_failure(input string what);
    if (fail_count_o < 10) begin
      $display("%0t checker: %s", $time, what);
    end
    fail_count_o++;
  endtask

  task automatic add_due(input res_t r);
    due_results.insert(due_results.size(), r);
  endtask

  task automatic predict_item(input logic [ACTION_W-1:0] act,
                              input logic [SLOT_W-1:0]   slot,
                              input logic [HANDLE_W-1:0] new_h,
                              input logic [HANDLE_W-1:0] exp_h);
    res_t        r;
    int unsigned cnt;
    int unsigned idx;
    int unsigned i;
    int unsigned start;
    int unsigned runs;
    cnt  = usable_slots();
    r    = '0;
    r.last = 1'b1;
    runs = 0;
    i    = 0;
    if (act == ACT_SET || act == ACT_CAS) begin
      if (slot >= win_base) begin
        idx = slot - win_base;
        if (idx < cnt && (act == ACT_SET || slot_handle[idx] == exp_h)) begin
          slot_handle[idx] = new_h;
          occupied[idx]    = (new_h != '0);
          r.applied        = 1'b1;
        end
      end
      add_due(r);
    end else if (act == ACT_LIST) begin
      while (i < cnt && runs < MAX_RESULTS) begin
        if (occupied[i]) begin
          start = i;
          while (i < cnt && occupied[i]) begin
            i++;
          end
          r.applied    = 1'b0;
          r.first_slot = SLOT_W'(win_base + start);
          r.run_length = LEN_W'(i - start);
          r.last       = 1'b0;
          add_due(r);
          runs++;
        end else begin
          i++;
        end
      end
      if (runs == 0) begin
        r = '0;
        r.last = 1'b1;
        add_due(r);
      end else begin
        r = due_results[due_results.size() - 1];
        r.last = 1'b1;
        due_results[due_results.size() - 1] = r;
      end
    end else begin
      add_due(r);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t got;
    res_t want;
    if (!rst_ni) begin
      foreach (slot_handle[k]) begin
        slot_handle[k] = '0;
      end
      occupied     = '0;
      win_base     = '0;
      win_count    = '0;
      fail_count_o = 0;
      due_results.delete();
    end else begin
      if (result_mon.valid && result_mon.ready) begin
        got.applied    = result_mon.applied;
        got.first_slot = result_mon.first_slot;
        got.run_length = result_mon.run_length;
        got.last       = result_mon.last;
        if (due_results.size() == 0) begin
          report_failure($sformatf(
            "unexpected result applied=%0b first_slot=%0d run_length=%0d last=%0b",
            got.applied, got.first_slot, got.run_length, got.last));
        end else begin
          want = due_results.pop_front();
          if (got.applied !== want.applied || got.first_slot !== want.first_slot ||
              got.run_length !== want.run_length || got.last !== want.last) begin
            report_failure($sformatf({"result mismatch: expected applied=%0b ",
              "first_slot=%0d run_length=%0d last=%0b, got applied=%0b ",
              "first_slot=%0d run_length=%0d last=%0b"},
              want.applied, want.first_slot, want.run_length, want.last,
              got.applied, got.first_slot, got.run_length, got.last));
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_BASE_SLOT) begin
          win_base = cfg_wdata_i[BASE_W-1:0];
        end else if (cfg_idx_i == CFG_SLOT_COUNT) begin
          win_count = cfg_wdata_i[SCNT_W-1:0];
        end
      end
      if (item_mon.valid && item_mon.ready) begin
        predict_item(item_mon.action, item_mon.slot_number, item_mon.new_handle,
                     item_mon.expected_handle);
      end
    end
    due_count_o = due_results.size();
  end

endmodule

[test/bound_slot_run_tracker_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bound_slot_run_tracker_top_tb
// Drives set, compare-and-set, list and unused actions into the slot run
// tracker over several slot windows, with random gaps on both channels, a
// long result stall and full drains. A checker beside the block predicts and
// compares every result; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module bound_slot_run_tracker_top_tb;
  import bsrt_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned IDLE_PCT    = 18;
  localparam int unsigned PHASE_ITEMS = 9;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;

  int unsigned          fail_count;
  int unsigned          due_count;
  int unsigned          cycle_count = 0;
  bit                   idle_on     = 1'b1;
  int unsigned          hold_reqs   = 0;
  logic [HANDLE_W-1:0]  slot_shadow [MAX_SLOTS];
  int unsigned          cur_base;
  int unsigned          cur_count;

  bsrt_in_if  item_if ();
  bsrt_out_if result_if ();

  bound_slot_run_tracker_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (item_if),
    .out_o       (result_if)
  );

  slot_result_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_mon     (item_if),
    .result_mon   (result_if),
    .fail_count_o (fail_count),
    .due_count_o  (due_count)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int unsigned hold_seen;
    int unsigned hold_left;
    hold_seen = 0;
    hold_left = 0;
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  function automatic int unsigned window_slots();
    return (cur_count < MAX_SLOTS) ? cur_count : MAX_SLOTS;
  endfunction

  function automatic logic [SLOT_W-1:0] window_slot(input int unsigned idx);
    return SLOT_W'(cur_base + idx);
  endfunction

  function automatic logic [HANDLE_W-1:0] pick_handle();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 3) begin
      return '0;
    end else if (pick == 3) begin
      return '1;
    end
    return $urandom;
  endfunction

  task automatic write_window(input logic [CFG_W-1:0] base_data,
                              input logic [CFG_W-1:0] count_data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_BASE_SLOT;
    cfg_wdata_i <= base_data;
    @(negedge clk_i);
    cfg_idx_i   <= CFG_SLOT_COUNT;
    cfg_wdata_i <= count_data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_base  = base_data[BASE_W-1:0];
    cur_count = count_data;
  endtask

  task automatic send_item(input logic [ACTION_W-1:0] act,
                           input logic [SLOT_W-1:0]   slot,
                           input logic [HANDLE_W-1:0] new_h,
                           input logic [HANDLE_W-1:0] exp_h);
    int unsigned idx;
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      item_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    item_if.valid           <= 1'b1;
    item_if.action          <= act;
    item_if.slot_number     <= slot;
    item_if.new_handle      <= new_h;
    item_if.expected_handle <= exp_h;
    if ((act == ACT_SET || act == ACT_CAS) && slot >= cur_base) begin
      idx = slot - cur_base;
      if (idx < window_slots() && (act == ACT_SET || slot_shadow[idx] == exp_h)) begin
        slot_shadow[idx] = new_h;
      end
    end
    do @(posedge clk_i); while (!item_if.ready);
    @(negedge clk_i);
  endtask

  task automatic drain();
    item_if.valid <= 1'b0;
    do @(negedge clk_i); while (due_count != 0);
  endtask

  task automatic random_item();
    int unsigned cnt;
    int unsigned pick;
    int unsigned idx;
    cnt  = window_slots();
    pick = $urandom_range(99);
    idx  = (cnt > 0) ? $urandom_range(cnt - 1) : 0;
    if (cnt == 0 && (pick < 63 || pick >= 95)) begin
      pick = 70;
    end
    if (pick < 40) begin
      send_item(ACT_SET, window_slot(idx), pick_handle(), $urandom);
    end else if (pick < 55) begin
      send_item(ACT_CAS, window_slot(idx), pick_handle(), slot_shadow[idx]);
    end else if (pick < 63) begin
      send_item(ACT_CAS, window_slot(idx), pick_handle(),
                slot_shadow[idx] ^ ($urandom | 32'h1));
    end else if (pick < 75) begin
      send_item($urandom_range(1) ? ACT_CAS : ACT_SET, SLOT_W'($urandom_range(255)),
                $urandom, $urandom);
    end else if (pick < 90) begin
      send_item(ACT_LIST, SLOT_W'($urandom), $urandom, $urandom);
    end else if (pick < 95) begin
      send_item(ACT_NONE, SLOT_W'($urandom), $urandom, $urandom);
    end else begin
      send_item(ACT_SET, window_slot(idx), '0, $urandom);
    end
  endtask

  initial begin
    rst_ni                  = 1'b0;
    cfg_we_i                = 1'b0;
    cfg_idx_i               = CFG_BASE_SLOT;
    cfg_wdata_i             = '0;
    item_if.valid           = 1'b0;
    item_if.action          = ACT_SET;
    item_if.slot_number     = '0;
    item_if.new_handle      = '0;
    item_if.expected_handle = '0;
    foreach (slot_shadow[k]) begin
      slot_shadow[k] = '0;
    end
    cur_base  = 0;
    cur_count = 0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty window after reset
    send_item(ACT_SET, 8'd0, 32'h0000_0001, 32'h0);
    send_item(ACT_LIST, 8'd0, 32'h0, 32'h0);
    send_item(ACT_NONE, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();

    write_window(8'd0, 8'd128);
    send_item(ACT_SET, 8'd0, 32'hFFFF_FFFF, 32'h0);
    send_item(ACT_SET, 8'd127, 32'h0000_0001, 32'h0);
    send_item(ACT_SET, 8'd128, 32'h0000_0007, 32'h0);
    send_item(ACT_CAS, 8'd0, 32'h5A5A_5A5A, 32'hFFFF_FFFF);
    send_item(ACT_CAS, 8'd0, 32'h0000_0001, 32'h0);
    send_item(ACT_SET, 8'd127, 32'h0000_0001, 32'h0);
    send_item(ACT_SET, 8'd1, 32'h8000_0000, 32'h0);
    send_item(ACT_SET, 8'd1, 32'h0, 32'h0);
    send_item(ACT_CAS, 8'd200, 32'h0000_0003, 32'h0);
    send_item(ACT_NONE, 8'hAA, 32'h5555_5555, 32'hAAAA_AAAA);
    send_item(ACT_LIST, 8'd0, 32'h0, 32'h0);
    drain();

    write_window(8'd127, 8'd128);
    send_item(ACT_SET, 8'd126, 32'h0000_0009, 32'h0);
    send_item(ACT_SET, 8'd254, 32'hFFFF_FFFF, 32'h0);
    send_item(ACT_SET, 8'd255, 32'h0000_0002, 32'h0);
    send_item(ACT_LIST, 8'd0, 32'h0, 32'h0);
    drain();

    write_window(8'd5, 8'd255);
    send_item(ACT_SET, 8'd132, 32'h0000_0004, 32'h0);
    send_item(ACT_SET, 8'd133, 32'h0000_0004, 32'h0);
    send_item(ACT_LIST, 8'd0, 32'h0, 32'h0);
    drain();

    write_window(8'd127, 8'd1);
    send_item(ACT_CAS, 8'd127, 32'h0000_0006, slot_shadow[0]);
    send_item(ACT_SET, 8'd128, 32'h0000_0006, 32'h0);
    send_item(ACT_LIST, 8'd0, 32'h0, 32'h0);
    drain();

    for (int unsigned phase = 0; phase < 6; phase++) begin
      idle_on = (phase != 2);
      case (phase)
        0: write_window(8'd0, 8'd128);
        1: write_window(CFG_W'($urandom_range(255)), CFG_W'($urandom_range(1, 128)));
        2: write_window(8'd127, 8'd128);
        3: write_window(CFG_W'($urandom_range(127)), CFG_W'($urandom_range(129, 255)));
        4: write_window(CFG_W'($urandom_range(127)), 8'd2);
        default: write_window(8'd0, 8'd128);
      endcase
      if (phase == 0) begin
        // alternate occupied and empty slots to get the most runs
        for (int unsigned i = 0; i < MAX_SLOTS; i++) begin
          if (i % 2 == 0) begin
            send_item(ACT_SET, window_slot(i), $urandom | 32'h1, $urandom);
          end else if (slot_shadow[i] != '0) begin
            send_item(ACT_SET, window_slot(i), '0, $urandom);
          end
        end
        hold_reqs++;
        send_item(ACT_LIST, SLOT_W'($urandom), $urandom, $urandom);
      end
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        random_item();
      end
      send_item(ACT_LIST, SLOT_W'($urandom), $urandom, $urandom);
      drain();
    end

    write_window(8'd0, 8'd0);
    send_item(ACT_LIST, 8'd0, 32'h0, 32'h0);
    drain();
    repeat (200) @(negedge clk_i);

    if (fail_count == 0 && due_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[bound_slot_run_tracker_top.f]
sv/bsrt_pkg.sv
sv/bsrt_if.sv
sv/bsrt_handle_ram.sv
sv/bsrt_seq.sv
sv/bsrt_out_reg.sv
sv/bound_slot_run_tracker_top.sv
test/slot_result_checker.sv
test/bound_slot_run_tracker_top_tb.sv
